/* hdl/fra_pkg.sv */
// ----------------------------------------------------------------------------
// fra_pkg: shared types and constants for the fraction arithmetic block
// Item structs for both channels, operation codes and the status bundle of
// the reduction unit.
// ----------------------------------------------------------------------------
package fra_pkg;

	localparam int FIELD_W = 16;
	localparam int CMD_W   = 2;
	localparam int NUM_W   = 33;
	localparam int DEN_W   = 31;

	// operation codes; any code other than subtract or multiply divides
	localparam logic [CMD_W-1:0] CMD_SUB = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MUL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DIV = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic signed [FIELD_W-1:0] a_num;
		logic signed [FIELD_W-1:0] a_den;
		logic signed [FIELD_W-1:0] b_num;
		logic signed [FIELD_W-1:0] b_den;
	} op_item_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] res_num;
		logic [DEN_W-1:0]        res_den;
		logic                    div_error;
	} res_item_t;

	// status of the gcd / exact divide unit
	typedef struct packed {
		logic busy;
		logic done;
	} red_stat_t;

endpackage

/* hdl/fra_reduce_unit.sv */
// ----------------------------------------------------------------------------
// fra_reduce_unit: gcd reduction of a magnitude pair
// Binary gcd with one compare/subtract/shift per cycle, then exact division
// of both magnitudes by the gcd, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fra_reduce_unit #(
	parameter int W = 33
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          mn,
	input  logic [W-1:0]          md,
	output fra_pkg::red_stat_t    stat,
	output logic [W-1:0]          qn,
	output logic [W-1:0]          qd
);
	import fra_pkg::*;

	localparam int KW = $clog2(W);
	localparam int CW = $clog2(W);

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_GCD  = 3'b010,
		U_DIV  = 3'b100
	} phase_t;

	phase_t        phase_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  x_q, y_q, g_q;
	logic [KW-1:0] k_q;
	logic [W-1:0]  n_q, d_q;
	logic [W-1:0]  rn_q, rd_q;

	logic          x_zero, y_zero, x_ge_y;
	logic [W-1:0]  g_next;
	logic [W:0]    tn, td;
	logic          bn, bd;
	logic          div_last;

	// gcd step decisions
	assign x_zero   = (x_q == '0);
	assign y_zero   = (y_q == '0);
	assign x_ge_y   = (x_q >= y_q);
	assign g_next   = (x_zero ? y_q : x_q) << k_q;

	// restoring divide step, both dividends against the same gcd
	assign tn       = {rn_q, n_q[W-1]};
	assign td       = {rd_q, d_q[W-1]};
	assign bn       = (tn >= {1'b0, g_q});
	assign bd       = (td >= {1'b0, g_q});
	assign div_last = (cnt_q == CW'(W - 1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= U_IDLE;
			cnt_q   <= '0;
		end else begin
			case (phase_q)
				U_IDLE: begin
					if (start) begin
						phase_q <= U_GCD;
					end
				end
				U_GCD: begin
					if (x_zero || y_zero) begin
						cnt_q   <= '0;
						phase_q <= (g_next == '0) ? U_IDLE : U_DIV;
					end
				end
				U_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (div_last) begin
						phase_q <= U_IDLE;
					end
				end
				default: phase_q <= U_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (phase_q)
			U_IDLE: begin
				if (start) begin
					x_q <= mn;
					y_q <= md;
					n_q <= mn;
					d_q <= md;
					k_q <= '0;
				end
			end
			U_GCD: begin
				if (x_zero || y_zero) begin
					g_q  <= g_next;
					rn_q <= '0;
					rd_q <= '0;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_ge_y) begin
					x_q <= (x_q - y_q) >> 1;
				end else begin
					y_q <= (y_q - x_q) >> 1;
				end
			end
			U_DIV: begin
				rn_q <= bn ? W'(tn - {1'b0, g_q}) : tn[W-1:0];
				rd_q <= bd ? W'(td - {1'b0, g_q}) : td[W-1:0];
				n_q  <= {n_q[W-2:0], bn};
				d_q  <= {d_q[W-2:0], bd};
			end
			default: ;
		endcase
	end

	assign stat.busy = (phase_q != U_IDLE);
	assign stat.done = ((phase_q == U_GCD) && (x_zero || y_zero) && (g_next == '0))
		|| ((phase_q == U_DIV) && div_last);
	assign qn = n_q;
	assign qd = d_q;

endmodule

/* hdl/fraction_arith_reduce.sv */
// Sequence: after acceptance, the multiply steps, the reduction start, the gcd loop (data
// dependent), the exact divide over W = 2*OPERAND_WIDTH+1 bits (skipped for 0/0) and the
// output state.
// Throughput: one item at a time; the next item is taken in the cycle after the result is
// loaded; a stalled result holds the block in output.
// Reset clears the sequencer and the output valid; no item is in flight after it.
// ----------------------------------------------------------------------------
// fraction_arith_reduce: signed fraction subtract / multiply / divide
// Forms the cross products with one shared multiplier, then reduces the
// result by its gcd and moves the sign onto the numerator.
// ----------------------------------------------------------------------------
module fraction_arith_reduce #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	output logic                op_stall,
	input  fra_pkg::op_item_t   op_item,
	output logic                res_valid,
	input  logic                res_stall,
	output fra_pkg::res_item_t  res_item
);
	import fra_pkg::*;

	localparam int OW = OPERAND_WIDTH;
	localparam int EW = (OW > FIELD_W) ? OW : FIELD_W;
	localparam int PW = 2 * OW;
	localparam int W  = 2 * OW + 1;
	localparam int XW = (W > NUM_W) ? W : NUM_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MUL   = 5'b00010,
		S_START = 5'b00100,
		S_RED   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t                state_q;
	logic [1:0]            mstep_q;
	logic                  res_valid_q;
	res_item_t             res_item_q;

	logic [CMD_W-1:0]      cmd_q;
	logic signed [OW-1:0]  an_q, ad_q, bn_q, bd_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [W-1:0]   num_q;
	logic signed [PW-1:0]  den_q;
	logic                  neg_q;

	logic                  is_sub, is_mul;
	logic signed [OW-1:0]  mul_a, mul_b;
	logic signed [PW-1:0]  prod_c;
	logic signed [W-1:0]   den_w;
	logic [W-1:0]          mn, md;
	logic                  red_start;
	red_stat_t             red_stat;
	logic [W-1:0]          qn, qd;
	logic [XW-1:0]         qn_x, qd_x, rn_x;
	logic                  out_free, accept;

	// operand field sign-extended from OW bits
	function automatic logic signed [OW-1:0] take_op(input logic [FIELD_W-1:0] f);
		logic [EW-1:0] z;
		z = EW'(f);
		return z[OW-1:0];
	endfunction

	assign accept   = op_valid && (state_q == S_IDLE);
	assign op_stall = (state_q != S_IDLE);
	assign out_free = !res_valid_q || !res_stall;

	// shared multiplier operand selection
	assign is_sub = (cmd_q == CMD_SUB);
	assign is_mul = (cmd_q == CMD_MUL);
	always_comb begin
		case (mstep_q)
			2'd0: begin
				mul_a = an_q;
				mul_b = is_mul ? bn_q : bd_q;
			end
			2'd1: begin
				mul_a = ad_q;
				mul_b = (is_sub || is_mul) ? bd_q : bn_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = bn_q;
			end
		endcase
	end
	assign prod_c = mul_a * mul_b;

	// magnitudes and sign of the raw fraction
	assign den_w     = W'(den_q);
	assign mn        = num_q[W-1] ? W'(-num_q) : W'(num_q);
	assign md        = den_w[W-1] ? W'(-den_w) : W'(den_w);
	assign red_start = (state_q == S_START);

	fra_reduce_unit #(
		.W(W)
	) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.mn     (mn),
		.md     (md),
		.stat   (red_stat),
		.qn     (qn),
		.qd     (qd)
	);

	// sign goes back onto the numerator
	assign qn_x = XW'(qn);
	assign qd_x = XW'(qd);
	assign rn_x = neg_q ? (~qn_x + 1'b1) : qn_x;

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mstep_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// load a finished item, else hold a stalled one, else drop a taken one
			res_valid_q <= ((state_q == S_OUT) && out_free) || (res_valid_q && res_stall);
			case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						mstep_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 2'd3) begin
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_RED;
				S_RED: begin
					if (red_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operand capture, products and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= op_item.cmd;
			an_q  <= take_op(op_item.a_num);
			ad_q  <= take_op(op_item.a_den);
			bn_q  <= take_op(op_item.b_num);
			bd_q  <= take_op(op_item.b_den);
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_c;
			case (mstep_q)
				2'd1: num_q <= W'(prod_q);
				2'd2: den_q <= prod_q;
				2'd3: begin
					if (is_sub) begin
						num_q <= num_q - W'(prod_q);
					end
				end
				default: ;
			endcase
		end
		if (state_q == S_START) begin
			neg_q <= num_q[W-1] != den_w[W-1];
		end
		if ((state_q == S_OUT) && out_free) begin
			res_item_q.res_num   <= rn_x[NUM_W-1:0];
			res_item_q.res_den   <= qd_x[DEN_W-1:0];
			res_item_q.div_error <= (qd == '0);
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// the reduction unit reports done only while the sequencer waits for it
	a_done_in_red: assert property (@(posedge clk) disable iff (!arst_n)
		red_stat.done |-> state_q == S_RED)
		else $error("reduction done outside wait state");

	// a new reduction never starts on a busy unit
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		red_start |-> !red_stat.busy)
		else $error("reduction started while busy");

	// a result appears only from the output state
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == S_OUT))
		else $error("result valid without a finished item");

	// a taken result is not shown again unless a new one was loaded
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && state_q != S_OUT |=> !res_valid)
		else $error("result repeated");

endmodule

/* test/fraction_arith_reduce_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fraction_arith_reduce_chk: result checker for the fraction arithmetic block
// Watches both channels. Each accepted operand item is turned into its
// expected reduced fraction and queued. Each accepted result item is compared
// field by field against the oldest queued fraction.
// ----------------------------------------------------------------------------
module fraction_arith_reduce_chk #(
	parameter int OPERAND_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	input  logic               op_stall,
	input  fra_pkg::op_item_t  op_item,
	input  logic               res_valid,
	input  logic               res_stall,
	input  fra_pkg::res_item_t res_item,
	output int                 pending,
	output int                 fail_count
);
	import fra_pkg::*;

	res_item_t expected_fracs[$];
	int        err_cnt = 0;

	assign fail_count = err_cnt;

	// one line per mismatch
	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	// operands are sign-extended from the configured operand width
	function automatic longint sext_operand(input logic [FIELD_W-1:0] f);
		longint v;
		v = longint'(f);
		v = (v <<< (64 - OPERAND_W)) >>> (64 - OPERAND_W);
		return v;
	endfunction

	// cross products, gcd on magnitudes, sign moved onto the numerator
	function automatic res_item_t reduce_fraction(input op_item_t it);
		longint          an, ad, bn, bd, num, den;
		longint unsigned mn, md, x, y, r;
		logic            neg;
		res_item_t       q;
		an = sext_operand(it.a_num);
		ad = sext_operand(it.a_den);
		bn = sext_operand(it.b_num);
		bd = sext_operand(it.b_den);
		if (it.cmd == CMD_SUB) begin
			num = an * bd - ad * bn;
			den = ad * bd;
		end else if (it.cmd == CMD_MUL) begin
			num = an * bn;
			den = ad * bd;
		end else begin
			// divide, also for the spare code
			num = an * bd;
			den = ad * bn;
		end
		mn = (num < 0) ? longint'(-num) : longint'(num);
		md = (den < 0) ? longint'(-den) : longint'(den);
		x = mn;
		y = md;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		// zero gcd only when both are zero: leave 0/0 as is
		if (x != 0) begin
			mn = mn / x;
			md = md / x;
		end
		neg = (num < 0) != (den < 0);
		q.res_num   = NUM_W'(neg ? (64'd0 - mn) : mn);
		q.res_den   = DEN_W'(md);
		q.div_error = (md == 0);
		return q;
	endfunction

	// queue on operand accept, compare on result accept
	always @(posedge clk) begin : watch
		res_item_t want;
		if (arst_n) begin
			if (op_valid && !op_stall)
				expected_fracs.push_back(reduce_fraction(op_item));
			if (res_valid && !res_stall) begin
				if (expected_fracs.size() == 0) begin
					report_error($sformatf("result %0d/%0d err %0b with no item pending",
						res_item.res_num, res_item.res_den, res_item.div_error));
				end else begin
					want = expected_fracs.pop_front();
					if (res_item.res_num !== want.res_num)
						report_error($sformatf("res_num %0d, want %0d",
							res_item.res_num, want.res_num));
					if (res_item.res_den !== want.res_den)
						report_error($sformatf("res_den %0d, want %0d",
							res_item.res_den, want.res_den));
					if (res_item.div_error !== want.div_error)
						report_error($sformatf("div_error %0b, want %0b",
							res_item.div_error, want.div_error));
				end
			end
		end
		pending <= expected_fracs.size();
	end

endmodule

/* test/fraction_arith_reduce_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fraction_arith_reduce_tb: top of the fraction arithmetic testbench
// Drives directed corner fractions, then bursts of random ones, while the
// result side stalls on its own pattern. The checker beside the block does
// all prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module fraction_arith_reduce_tb;
	import fra_pkg::*;

	localparam int OPERAND_W    = 16;
	localparam int RAND_ITEMS   = 400;
	localparam int DRAIN_CYCLES = 150;
	localparam int LIMIT_CYCLES = 1000000;

	// spare operation code, decodes as divide
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BLOCKS
	} stall_mode_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      op_valid  = 1'b0;
	op_item_t  op_item   = '0;
	logic      res_stall = 1'b0;
	logic      op_stall;
	logic      res_valid;
	res_item_t res_item;
	int        pending;
	int        fail_count;
	int        cycle_cnt = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	int          blk_left   = 0;
	logic        blk_on     = 1'b0;

	fraction_arith_reduce #(
		.OPERAND_WIDTH(OPERAND_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.op_item   (op_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	fraction_arith_reduce_chk #(
		.OPERAND_W(OPERAND_W)
	) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (op_valid),
		.op_stall   (op_stall),
		.op_item    (op_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always #2 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("FAIL fraction_arith_reduce");
			$finish;
		end
	end

	// result side stall pattern: a random mode, redrawn when its run ends
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			mode_left  <= $urandom_range(64, 400);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  res_stall <= 1'b0;
			STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (blk_left == 0) begin
					blk_on    <= ~blk_on;
					blk_left  <= $urandom_range(1, 16);
					res_stall <= ~blk_on;
				end else begin
					blk_left  <= blk_left - 1;
					res_stall <= blk_on;
				end
			end
		endcase
	end

	function automatic op_item_t mk_op(input logic [CMD_W-1:0] cmd,
		input int an, input int ad, input int bn, input int bd);
		op_item_t it;
		it.cmd   = cmd;
		it.a_num = FIELD_W'(an);
		it.a_den = FIELD_W'(ad);
		it.b_num = FIELD_W'(bn);
		it.b_den = FIELD_W'(bd);
		return it;
	endfunction

	// mix of zeros, extremes, small values, multiples of 512 (many common factors) and full range
	function automatic logic [FIELD_W-1:0] rand_field();
		case ($urandom_range(0, 9))
			0: return '0;
			1: begin
				case ($urandom_range(0, 3))
					0: return FIELD_W'(-32768);
					1: return FIELD_W'(32767);
					2: return FIELD_W'(1);
					default: return FIELD_W'(-1);
				endcase
			end
			2, 3, 4: return FIELD_W'(int'($urandom_range(0, 48)) - 24);
			5: return FIELD_W'((int'($urandom_range(0, 64)) - 32) * 512);
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	function automatic op_item_t rand_op();
		op_item_t it;
		it.cmd   = CMD_W'($urandom_range(0, 3));
		it.a_num = rand_field();
		it.a_den = rand_field();
		it.b_num = rand_field();
		it.b_den = rand_field();
		return it;
	endfunction

	// present one item and hold it until accepted
	task automatic push_op(input op_item_t it);
		op_valid <= 1'b1;
		op_item  <= it;
		@(posedge clk);
		while (op_stall)
			@(posedge clk);
	endtask

	task automatic idle(input int n);
		op_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		idle(1);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin : stim
		int sent;
		int burst;
		int gap;
		bit paused;
		sent   = 0;
		paused = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed corners, back to back
		push_op(mk_op(CMD_SUB, 1, 2, 1, 3));
		push_op(mk_op(CMD_SUB, 1, 2, 1, 2));
		push_op(mk_op(CMD_MUL, 2, 3, 3, 4));
		push_op(mk_op(CMD_DIV, 2, 3, 4, 9));
		push_op(mk_op(CMD_SPARE, 2, 3, 4, 9));
		push_op(mk_op(CMD_MUL, 1, -2, 1, 3));
		push_op(mk_op(CMD_DIV, -1, 2, -1, 3));
		// zero raw denominator, either sign of numerator
		push_op(mk_op(CMD_MUL, 3, 0, 5, 7));
		push_op(mk_op(CMD_MUL, -3, 0, 5, 7));
		push_op(mk_op(CMD_DIV, 3, 4, 0, 5));
		// zero over zero
		push_op(mk_op(CMD_MUL, 0, 0, 5, 7));
		push_op(mk_op(CMD_SUB, 3, 0, 5, 0));
		// zero numerator, nonzero denominator
		push_op(mk_op(CMD_MUL, 0, 5, 3, 4));
		// field extremes
		push_op(mk_op(CMD_MUL, 1, -32768, 1, -32768));
		push_op(mk_op(CMD_MUL, -32768, -32768, -32768, -32768));
		push_op(mk_op(CMD_MUL, 32767, 1, 32767, 1));
		push_op(mk_op(CMD_SUB, -32768, -32768, 32767, -32768));
		push_op(mk_op(CMD_SUB, 32767, -32768, -32768, 32767));
		push_op(mk_op(CMD_DIV, -32768, 32767, 32767, -32768));
		push_op(mk_op(CMD_DIV, 32767, 32767, -32768, -32768));
		push_op(mk_op(CMD_SPARE, -32768, 1, 1, -32768));
		push_op(mk_op(CMD_SUB, 32767, 32767, -32768, 1));
		wait_drained();

		// random bursts with random gaps
		while (sent < RAND_ITEMS) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst; i++) begin
				push_op(rand_op());
				sent++;
			end
			if (!paused && sent >= RAND_ITEMS / 2) begin
				// hold off until the block has emptied
				paused = 1'b1;
				wait_drained();
			end else begin
				case ($urandom_range(0, 7))
					0, 1, 2, 3: gap = 0;
					4, 5:       gap = $urandom_range(1, 8);
					6:          gap = $urandom_range(9, 40);
					default:    gap = $urandom_range(41, 130);
				endcase
				if (gap > 0)
					idle(gap);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS fraction_arith_reduce");
		else
			$display("FAIL fraction_arith_reduce");
		$finish;
	end

endmodule
